// ===== rtl/l2nm_pkg.sv =====
// ----------------------------------------------------------------------------
// l2nm_pkg: shared types and constants of the L2 normalize and match block
// Holds widths, command codes and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
package l2nm_pkg;

    // Vector store depth and derived widths.
    localparam int MAX_DIM  = 1024;
    localparam int ADDR_W   = 10;
    localparam int LEN_W    = 11;
    localparam int SAMPLE_W = 16;
    localparam int SQSUM_W  = 41;
    localparam int DOT_W    = 42;
    localparam int ROOT_W   = 31;
    localparam int QUOT_W   = 17;

    // Iteration counts of the shared square root and divider steps.
    localparam int SQRT_STEPS = ROOT_W;
    localparam int DIV_STEPS  = QUOT_W;

    // Command codes on the input tuser; result kinds use the same codes.
    localparam logic [1:0] CMD_QUERY = 2'd0;
    localparam logic [1:0] CMD_REF   = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_NOP   = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;
        logic acc;
        logic prep;
        logic sqrt_step;
        logic norm_rd;
        logic div_init;
        logic div_step;
        logic norm_wr;
        logic finish;
        logic dot_rd;
        logic dot_mul;
        logic dot_acc;
        logic rb_rd;
        logic post;
    } l2nm_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last;
        logic skip_norm;
        logic sqrt_done;
        logic div_done;
        logic idx_last;
        logic dot_needed;
        logic out_free;
    } l2nm_stat_t;

endpackage

// ===== rtl/l2nm_ram.sv =====
// ----------------------------------------------------------------------------
// l2nm_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module l2nm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/l2nm_dp.sv =====
// ----------------------------------------------------------------------------
// l2nm_dp: datapath of the L2 normalize and match block
// Vector stores, sum of squares, bit-serial square root and divider,
// dot product accumulator and the result word register.
// ----------------------------------------------------------------------------
module l2nm_dp (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  l2nm_pkg::l2nm_cmd_t  cmd,
    output l2nm_pkg::l2nm_stat_t stat,
    input  logic [31:0]          s_tdata,
    input  logic                 s_tlast,
    input  logic [1:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [47:0]          m_tdata,
    output logic [1:0]           m_tuser
);
    import l2nm_pkg::*;

    // Item fields.
    logic signed [SAMPLE_W-1:0] x_in;
    logic [ADDR_W-1:0]          idx_in;

    // Control state.
    logic [1:0]       cmd_reg;
    logic             last_reg;
    logic             target_reg, target_next;
    logic [LEN_W-1:0] load_count_reg, load_count_next;
    logic             overlong_reg, overlong_next;
    logic [LEN_W-1:0] query_len_reg, ref_len_reg;
    logic             ref_valid_reg;
    logic             m_tvalid_reg;

    // Payload registers.
    logic [ADDR_W-1:0]  rb_idx_reg;
    logic [SQSUM_W-1:0] sqsum_reg;
    logic [30:0]        sq_prod_reg;
    logic [ROOT_W-1:0]  root_reg;
    logic [32:0]        sq_rem_reg;
    logic [61:0]        sq_rad_reg;
    logic [4:0]         step_reg;
    logic [LEN_W-1:0]   elem_idx_reg;
    logic [31:0]        div_rem_reg;
    logic [QUOT_W-1:0]  div_low_reg;
    logic [QUOT_W-1:0]  quot_reg;
    logic               neg_reg;
    logic               err_reg;
    logic               match_reg;
    logic [DOT_W-1:0]   dot_sum_reg;
    logic [31:0]        dot_prod_reg;
    logic [47:0]        m_tdata_reg;
    logic [1:0]         m_tuser_reg;

    // Load decode.
    logic             load_go;
    logic             start_load;
    logic [LEN_W-1:0] cnt_eff;
    logic             room;
    logic [31:0]      sq_full;

    // Memory ports.
    logic                q_we, r_we, q_re, r_re;
    logic [ADDR_W-1:0]   waddr, q_raddr, r_raddr;
    logic [SAMPLE_W-1:0] wdata, q_rdata, r_rdata, sel_rdata;

    // Arithmetic.
    logic [15:0]       mag;
    logic [40:0]       num;
    logic [31:0]       div_trial;
    logic              div_ge;
    logic [34:0]       sq_rem2, sq_trial;
    logic              sq_ge;
    logic [QUOT_W-1:0] quot_clamp;
    logic [15:0]       norm_y;
    logic [42:0]       dot_round;
    logic [27:0]       dot_shift;
    logic [15:0]       score;
    logic              err_now;
    logic              rb_bad;

    assign x_in   = s_tdata[15:0];
    assign idx_in = s_tdata[25:16];

    // Start of a new load and the slot the element goes to.
    assign load_go    = cmd.take && (s_tuser == CMD_QUERY || s_tuser == CMD_REF);
    assign start_load = (load_count_reg == '0 && !overlong_reg) || (s_tuser[0] != target_reg);
    assign cnt_eff    = start_load ? '0 : load_count_reg;
    assign room       = cnt_eff < LEN_W'(MAX_DIM);
    assign sq_full    = x_in * x_in;

    // Store ports: loads write at the fill count, normalization writes back.
    assign q_we  = (load_go && room && s_tuser == CMD_QUERY) || (cmd.norm_wr && !target_reg);
    assign r_we  = (load_go && room && s_tuser == CMD_REF) || (cmd.norm_wr && target_reg);
    assign waddr = cmd.take ? cnt_eff[ADDR_W-1:0] : elem_idx_reg[ADDR_W-1:0];
    assign wdata = cmd.take ? x_in : norm_y;
    assign q_re  = cmd.rb_rd || cmd.dot_rd || (cmd.norm_rd && !target_reg);
    assign r_re  = cmd.dot_rd || (cmd.norm_rd && target_reg);
    assign q_raddr = cmd.rb_rd ? rb_idx_reg : elem_idx_reg[ADDR_W-1:0];
    assign r_raddr = elem_idx_reg[ADDR_W-1:0];
    assign sel_rdata = target_reg ? r_rdata : q_rdata;

    l2nm_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_DIM)) u_query_ram (
        .aclk  (aclk),
        .we    (q_we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (q_re),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    l2nm_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_DIM)) u_ref_ram (
        .aclk  (aclk),
        .we    (r_we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (r_re),
        .raddr (r_raddr),
        .rdata (r_rdata)
    );

    // Square root step: one root bit per cycle from two radicand bits.
    assign sq_rem2  = {sq_rem_reg, sq_rad_reg[61:60]};
    assign sq_trial = {2'b00, root_reg, 2'b01};
    assign sq_ge    = sq_rem2 >= sq_trial;

    // Divider setup: rounded numerator of the scaled magnitude.
    assign mag = sel_rdata[15] ? (~sel_rdata + 16'd1) : sel_rdata;
    assign num = {mag, 25'd0} + {11'd0, root_reg[ROOT_W-1:1]};

    // Divider step: one quotient bit per cycle.
    assign div_trial = {div_rem_reg[30:0], div_low_reg[QUOT_W-1]};
    assign div_ge    = div_trial >= {1'b0, root_reg};

    // Clamp the quotient and apply the sign.
    always_comb begin
        quot_clamp = (quot_reg > QUOT_W'(32768)) ? QUOT_W'(32768) : quot_reg;
        if (neg_reg) begin
            norm_y = 16'(~quot_clamp + QUOT_W'(1));
        end else if (quot_clamp == QUOT_W'(32768)) begin
            norm_y = 16'h7FFF;
        end else begin
            norm_y = quot_clamp[15:0];
        end
    end

    // Score: add half an LSB, floor shift, saturate.
    assign dot_round = {dot_sum_reg[DOT_W-1], dot_sum_reg} + 43'd16384;
    assign dot_shift = dot_round[42:15];
    always_comb begin
        if ($signed(dot_shift) > 28'sd32767) begin
            score = 16'h7FFF;
        end else if ($signed(dot_shift) < -28'sd32768) begin
            score = 16'h8000;
        end else begin
            score = dot_shift[15:0];
        end
    end

    assign err_now = overlong_reg || load_count_reg == '0;
    assign rb_bad  = {1'b0, rb_idx_reg} >= query_len_reg;

    // Status to the controller.
    assign stat.last       = last_reg;
    assign stat.skip_norm  = err_now || sqsum_reg == '0;
    assign stat.sqrt_done  = step_reg == '0;
    assign stat.div_done   = step_reg == '0;
    assign stat.idx_last   = elem_idx_reg == load_count_reg - LEN_W'(1);
    assign stat.dot_needed = !target_reg && !err_now && ref_valid_reg
                             && ref_len_reg == load_count_reg;
    assign stat.out_free   = !m_tvalid_reg || m_tready;

    // Fill count and overlong flag of the load in progress.
    always_comb begin
        target_next     = target_reg;
        load_count_next = load_count_reg;
        overlong_next   = overlong_reg;
        if (load_go) begin
            target_next = s_tuser[0];
            if (room) begin
                load_count_next = cnt_eff + LEN_W'(1);
                overlong_next   = 1'b0;
            end else begin
                load_count_next = cnt_eff;
                overlong_next   = 1'b1;
            end
        end else if (cmd.post && cmd_reg != CMD_READ) begin
            load_count_next = '0;
            overlong_next   = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg     <= 1'b0;
            load_count_reg <= '0;
            overlong_reg   <= 1'b0;
            query_len_reg  <= '0;
            ref_len_reg    <= '0;
            ref_valid_reg  <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            cmd_reg        <= CMD_NOP;
            last_reg       <= 1'b0;
        end else begin
            target_reg     <= target_next;
            load_count_reg <= load_count_next;
            overlong_reg   <= overlong_next;
            if (cmd.take) begin
                cmd_reg  <= s_tuser;
                last_reg <= s_tlast;
            end
            if (load_go && start_load) begin
                if (s_tuser == CMD_QUERY) begin
                    query_len_reg <= '0;
                end else begin
                    ref_len_reg   <= '0;
                    ref_valid_reg <= 1'b0;
                end
            end
            if (cmd.finish) begin
                if (!target_reg) begin
                    query_len_reg <= err_now ? '0 : load_count_reg;
                end else begin
                    ref_len_reg   <= err_now ? '0 : load_count_reg;
                    ref_valid_reg <= !err_now;
                end
            end
            if (cmd.post) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Arithmetic registers.
    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            rb_idx_reg <= idx_in;
        end
        if (load_go) begin
            sq_prod_reg <= room ? sq_full[30:0] : '0;
            if (start_load) begin
                sqsum_reg <= '0;
            end
        end else if (cmd.acc) begin
            sqsum_reg <= sqsum_reg + {10'd0, sq_prod_reg};
        end else if (cmd.post && cmd_reg != CMD_READ) begin
            sqsum_reg <= '0;
        end
        if (cmd.prep) begin
            sq_rad_reg   <= {1'b0, sqsum_reg, 20'd0};
            root_reg     <= '0;
            sq_rem_reg   <= '0;
            step_reg     <= 5'(SQRT_STEPS - 1);
            elem_idx_reg <= '0;
        end
        if (cmd.sqrt_step) begin
            sq_rem_reg <= sq_ge ? 33'(sq_rem2 - sq_trial) : sq_rem2[32:0];
            root_reg   <= {root_reg[ROOT_W-2:0], sq_ge};
            sq_rad_reg <= {sq_rad_reg[59:0], 2'b00};
            step_reg   <= step_reg - 5'd1;
        end
        if (cmd.div_init) begin
            div_rem_reg <= {8'd0, num[40:17]};
            div_low_reg <= num[16:0];
            quot_reg    <= '0;
            neg_reg     <= sel_rdata[15];
            step_reg    <= 5'(DIV_STEPS - 1);
        end
        if (cmd.div_step) begin
            div_rem_reg <= div_ge ? div_trial - {1'b0, root_reg} : div_trial;
            div_low_reg <= {div_low_reg[QUOT_W-2:0], 1'b0};
            quot_reg    <= {quot_reg[QUOT_W-2:0], div_ge};
            step_reg    <= step_reg - 5'd1;
        end
        if (cmd.norm_wr || cmd.dot_acc) begin
            elem_idx_reg <= elem_idx_reg + LEN_W'(1);
        end
        if (cmd.finish) begin
            err_reg      <= err_now;
            match_reg    <= stat.dot_needed;
            dot_sum_reg  <= '0;
            elem_idx_reg <= '0;
        end
        if (cmd.dot_mul) begin
            dot_prod_reg <= 32'($signed(q_rdata) * $signed(r_rdata));
        end
        if (cmd.dot_acc) begin
            dot_sum_reg <= dot_sum_reg + {{10{dot_prod_reg[31]}}, dot_prod_reg};
        end
        // Result word: status, length, match flag, score, element.
        if (cmd.post) begin
            m_tuser_reg <= cmd_reg;
            if (cmd_reg == CMD_READ) begin
                m_tdata_reg <= {3'd0, (rb_bad ? 16'd0 : q_rdata), 16'd0, 1'b0,
                                query_len_reg, rb_bad};
            end else begin
                m_tdata_reg <= {3'd0, 16'd0, (match_reg ? score : 16'd0), match_reg,
                                (err_reg ? LEN_W'(0) : load_count_reg), err_reg};
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // The fill count never passes the store depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        load_count_reg <= LEN_W'(MAX_DIM))
        else $error("load count beyond store depth");

    // Dropped elements only occur once the store is full.
    a_overlong_full: assert property (@(posedge aclk) disable iff (!aresetn)
        overlong_reg |-> load_count_reg == LEN_W'(MAX_DIM))
        else $error("overlong flag with store not full");

    // A valid reference always has a nonzero length and an invalid one none.
    a_ref_len: assert property (@(posedge aclk) disable iff (!aresetn)
        ref_valid_reg == (ref_len_reg != '0))
        else $error("reference valid flag and length disagree");

    // A result is only posted into a free output register.
    a_post_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.post |-> (!$past(1'b0) && (!m_tvalid_reg || m_tready)))
        else $error("result posted over a pending word");

endmodule

// ===== rtl/l2nm_ctrl.sv =====
// ----------------------------------------------------------------------------
// l2nm_ctrl: controller of the L2 normalize and match block
// Sequences loading, square root, normalization, dot product and readback.
// ----------------------------------------------------------------------------
module l2nm_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [1:0]           s_tuser,
    output l2nm_pkg::l2nm_cmd_t  cmd,
    input  l2nm_pkg::l2nm_stat_t stat
);
    import l2nm_pkg::*;

    typedef enum logic [13:0] {
        ST_IDLE = 14'h0001,
        ST_ACC  = 14'h0002,
        ST_PREP = 14'h0004,
        ST_SQRT = 14'h0008,
        ST_NRD  = 14'h0010,
        ST_NLD  = 14'h0020,
        ST_NDIV = 14'h0040,
        ST_NWR  = 14'h0080,
        ST_FIN  = 14'h0100,
        ST_DRD  = 14'h0200,
        ST_DMUL = 14'h0400,
        ST_DACC = 14'h0800,
        ST_RB   = 14'h1000,
        ST_POST = 14'h2000
    } l2nm_state_t;

    l2nm_state_t state_reg, state_next;

    assign s_tready = state_reg == ST_IDLE;

    // Next state and datapath commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.take = 1'b1;
                    unique case (s_tuser)
                        CMD_READ: state_next = ST_RB;
                        CMD_NOP:  state_next = ST_IDLE;
                        default:  state_next = ST_ACC;
                    endcase
                end
            end
            ST_ACC: begin
                cmd.acc    = 1'b1;
                state_next = stat.last ? ST_PREP : ST_IDLE;
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = stat.skip_norm ? ST_FIN : ST_SQRT;
            end
            ST_SQRT: begin
                cmd.sqrt_step = 1'b1;
                if (stat.sqrt_done) begin
                    state_next = ST_NRD;
                end
            end
            ST_NRD: begin
                cmd.norm_rd = 1'b1;
                state_next  = ST_NLD;
            end
            ST_NLD: begin
                cmd.div_init = 1'b1;
                state_next   = ST_NDIV;
            end
            ST_NDIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_done) begin
                    state_next = ST_NWR;
                end
            end
            ST_NWR: begin
                cmd.norm_wr = 1'b1;
                state_next  = stat.idx_last ? ST_FIN : ST_NRD;
            end
            ST_FIN: begin
                cmd.finish = 1'b1;
                state_next = stat.dot_needed ? ST_DRD : ST_POST;
            end
            ST_DRD: begin
                cmd.dot_rd = 1'b1;
                state_next = ST_DMUL;
            end
            ST_DMUL: begin
                cmd.dot_mul = 1'b1;
                state_next  = ST_DACC;
            end
            ST_DACC: begin
                cmd.dot_acc = 1'b1;
                state_next  = stat.idx_last ? ST_POST : ST_DRD;
            end
            ST_RB: begin
                cmd.rb_rd  = 1'b1;
                state_next = ST_POST;
            end
            ST_POST: begin
                if (stat.out_free) begin
                    cmd.post   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Items are only taken when the sequencer is at rest.
    a_take_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.take |=> state_reg != ST_IDLE || $past(s_tuser) == CMD_NOP)
        else $error("item taken without leaving idle");

    // The divider always runs after its setup cycle.
    a_div_after_init: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_init |=> cmd.div_step)
        else $error("divider not started after setup");

    // A finished normalization pass ends in the finish step.
    a_norm_to_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.norm_wr && stat.idx_last) |=> cmd.finish)
        else $error("normalization pass did not finish");

endmodule

// ===== rtl/l2_normalize_and_match.sv =====
// ----------------------------------------------------------------------------
// l2_normalize_and_match: L2 normalization and cosine match of Q3.12 vectors
// Loads query and reference vectors, normalizes them to Q1.15 and scores a
// query against the stored reference; stored query elements can be read back.
// ----------------------------------------------------------------------------
//  Channel  Dir  tdata (low bit first)                         tuser     tlast
//  s_       in   sample_value[15:0] read_index[25:16]          cmd       last_element
//  m_       out  status[0] vector_length[11:1] hit_flag[12]    result_kind  -
//                hit_score[28:13] element_out[44:29]
//
//  A non-final element is accumulated; a readback reads the query store and posts
//  once the output is free. A final element runs the square root bit by bit, then
//  normalizes each element (17-step bit-serial divider), then, for a query while a
//  reference of equal length is held, takes the dot product element by element;
//  an error or all-zero vector skips root and normalization.
//  Reset clears all control state; the stores need no clearing pass.
//  A stalled m_ side holds a finished word while the next item is taken.
// ----------------------------------------------------------------------------
module l2_normalize_and_match (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // sample_value, read_index
    input  logic [1:0]  s_tuser,   // cmd
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // status, vector_length, hit_flag,
                                   // hit_score, element_out
    output logic [1:0]  m_tuser    // result_kind
);
    import l2nm_pkg::*;

    l2nm_cmd_t  cmd;
    l2nm_stat_t stat;

    l2nm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .stat     (stat)
    );

    l2nm_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
